>>> src/flt_pkg.sv
// Shared types and constants for the fault-line terrain update block.
// Used by flt_cfg, flt_store, flt_ctrl and the top level; no dependencies.
package flt_pkg;

	localparam int HEIGHT_W = 24;
	localparam int DISP_W   = 10;
	localparam int COORD_W  = 7;
	localparam int CNT_W    = 8;

	localparam logic [HEIGHT_W-1:0] HEIGHT_TOP = '1;

	typedef enum logic [1:0] {
		OP_FAULT = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_ROWS   = 2'd0,
		REG_COLS   = 2'd1,
		REG_MSTART = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_SETUP_A,
		ST_SETUP_B,
		ST_SCAN,
		ST_DRAIN_A,
		ST_DRAIN_B,
		ST_READ,
		ST_FINISH
	} state_t;

	// per-cycle command from the sequencer to the height store
	typedef struct packed {
		logic visit;     // read-modify-write of one cell
		logic rise;      // cell lies on the positive side of the line
		logic clear_wr;  // write zero at the address
		logic load_max;  // running max <= configured start value
	} cmd_t;

endpackage

>>> src/flt_cfg.sv
// APB-style configuration registers: rows/cols in use and max height start.
// Depends on flt_pkg.
module flt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [flt_pkg::CNT_W-1:0]       rows_in_use,
	output logic [flt_pkg::CNT_W-1:0]       cols_in_use,
	output logic [flt_pkg::HEIGHT_W-1:0]    max_height_start
);

	logic [flt_pkg::CNT_W-1:0]    rows_q;
	logic [flt_pkg::CNT_W-1:0]    cols_q;
	logic [flt_pkg::HEIGHT_W-1:0] mstart_q;
	logic                         wr_en;
	flt_pkg::reg_idx_t            idx;

	assign idx   = flt_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= 8'd128;
			cols_q   <= 8'd128;
			mstart_q <= '0;
		end else if (wr_en) begin
			case (idx)
				flt_pkg::REG_ROWS:   rows_q   <= pwdata[flt_pkg::CNT_W-1:0];
				flt_pkg::REG_COLS:   cols_q   <= pwdata[flt_pkg::CNT_W-1:0];
				flt_pkg::REG_MSTART: mstart_q <= pwdata[flt_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			flt_pkg::REG_ROWS:   prdata = {24'd0, rows_q};
			flt_pkg::REG_COLS:   prdata = {24'd0, cols_q};
			flt_pkg::REG_MSTART: prdata = {8'd0, mstart_q};
			default:             prdata = '0;
		endcase
	end

	assign rows_in_use      = rows_q;
	assign cols_in_use      = cols_q;
	assign max_height_start = mstart_q;

endmodule

>>> src/flt_store.sv
// Height memory with the cell update pipeline and the running maximum.
// Depends on flt_pkg; driven by flt_ctrl through flt_pkg::cmd_t.
module flt_store #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  flt_pkg::cmd_t                   cmd,
	input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] addr,
	input  logic [flt_pkg::DISP_W-1:0]      disp,
	input  logic [flt_pkg::HEIGHT_W-1:0]    max_start,
	output logic [flt_pkg::HEIGHT_W-1:0]    rd_data,
	output logic [flt_pkg::HEIGHT_W-1:0]    max_height
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int HW    = flt_pkg::HEIGHT_W;

	logic [HW-1:0] mem [0:DEPTH-1];
	logic [HW-1:0] rd_q;

	logic          visit_s1;
	logic          rise_s1;
	logic [AW-1:0] addr_s1;
	logic          visit_s2;
	logic [HW-1:0] h_s2;
	logic [HW-1:0] max_q;

	logic [HW:0]   sum;
	logic [HW-1:0] disp_ext;
	logic [HW-1:0] new_h;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [HW-1:0] wr_data;

	assign disp_ext = {{(HW-flt_pkg::DISP_W){1'b0}}, disp};
	assign sum      = {1'b0, rd_q} + {1'b0, disp_ext};

	// rise saturates at the top; fall only when the height stays non-negative
	always_comb begin
		if (rise_s1)
			new_h = sum[HW] ? flt_pkg::HEIGHT_TOP : sum[HW-1:0];
		else if (rd_q >= disp_ext)
			new_h = rd_q - disp_ext;
		else
			new_h = rd_q;
	end

	assign wr_en   = visit_s1 || cmd.clear_wr;
	assign wr_addr = visit_s1 ? addr_s1 : addr;
	assign wr_data = visit_s1 ? new_h : '0;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visit_s1 <= 1'b0;
			visit_s2 <= 1'b0;
			max_q    <= '0;
		end else begin
			visit_s1 <= cmd.visit;
			visit_s2 <= visit_s1;
			if (cmd.load_max)
				max_q <= max_start;
			else if (visit_s2 && (h_s2 > max_q))
				max_q <= h_s2;
		end
	end

	always_ff @(posedge clk) begin
		rise_s1 <= cmd.rise;
		addr_s1 <= addr;
		h_s2    <= new_h;
	end

	assign rd_data    = rd_q;
	assign max_height = max_q;

endmodule

>>> src/flt_ctrl.sv
// Sequencer: takes requests, walks the grid with one shared adder for the
// line side test, sweeps the store on clear and registers the result.
// Depends on flt_pkg; drives flt_store.
module flt_ctrl #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      opcode,
	input  logic [flt_pkg::COORD_W-1:0]     line_a_row,
	input  logic [flt_pkg::COORD_W-1:0]     line_a_col,
	input  logic [flt_pkg::COORD_W-1:0]     line_b_row,
	input  logic [flt_pkg::COORD_W-1:0]     line_b_col,
	input  logic [flt_pkg::DISP_W-1:0]      displacement,
	input  logic [flt_pkg::COORD_W-1:0]     read_row,
	input  logic [flt_pkg::COORD_W-1:0]     read_col,
	input  logic [flt_pkg::CNT_W-1:0]       rows_in_use,
	input  logic [flt_pkg::CNT_W-1:0]       cols_in_use,
	output flt_pkg::cmd_t                   cmd,
	output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] addr,
	output logic [flt_pkg::DISP_W-1:0]      disp,
	input  logic [flt_pkg::HEIGHT_W-1:0]    rd_data,
	input  logic [flt_pkg::HEIGHT_W-1:0]    max_cur,
	output logic                            done,
	output logic [flt_pkg::HEIGHT_W-1:0]    cell_height,
	output logic [flt_pkg::HEIGHT_W-1:0]    max_height
);

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int AW  = RW + CW;
	localparam int CO  = flt_pkg::COORD_W;
	// line points reach 2^COORD_W - 1 even on a small grid
	localparam int MW  = (RW > CW) ? RW : CW;
	localparam int SW  = ((MW > CO) ? MW : CO) + 10;
	localparam int RLW = RW + 9;
	localparam int CLW = CW + 9;
	localparam int HW  = flt_pkg::HEIGHT_W;

	flt_pkg::state_t state_q, state_d;

	logic             accept;
	flt_pkg::op_t     op_in;
	logic             reply_q;
	logic [AW-1:0]    sweep_q;
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic             done_q;

	flt_pkg::op_t     op_q;
	logic signed [7:0] dr_q;
	logic signed [7:0] dc_q;
	logic [CO-1:0]    ar_q;
	logic [CO-1:0]    ac_q;
	logic [flt_pkg::DISP_W-1:0] disp_q;
	logic [RW-1:0]    row_last_q;
	logic [CW-1:0]    col_last_q;
	logic             empty_q;
	logic [AW-1:0]    rd_addr_q;
	logic             rd_ok_q;
	logic signed [SW-1:0] s_row_q;
	logic signed [SW-1:0] s_cur_q;
	logic [HW-1:0]    cell_q;
	logic [HW-1:0]    maxo_q;

	logic [RLW-1:0]   rows_ext, nr, nr_m1;
	logic [CLW-1:0]   cols_ext, nc, nc_m1;
	logic [RW+CO-1:0] rr_ext;
	logic [CW+CO-1:0] rc_ext;
	logic             row_end;
	logic             scan_last;
	logic             sweep_last;

	// shared multiplier for the line offset at cell (0, 0)
	logic signed [7:0]  mul_a;
	logic signed [7:0]  mul_b;
	logic signed [15:0] prod;
	// shared adder stepping the cross product across the grid
	logic signed [SW-1:0] add_a;
	logic signed [SW-1:0] add_b;
	logic signed [SW-1:0] s_next;

	assign op_in  = flt_pkg::op_t'(opcode);
	assign busy   = (state_q != flt_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign rows_ext = {{(RLW-flt_pkg::CNT_W){1'b0}}, rows_in_use};
	assign cols_ext = {{(CLW-flt_pkg::CNT_W){1'b0}}, cols_in_use};
	assign nr       = (rows_ext > RLW'(MAX_ROWS)) ? RLW'(MAX_ROWS) : rows_ext;
	assign nc       = (cols_ext > CLW'(MAX_COLS)) ? CLW'(MAX_COLS) : cols_ext;
	assign nr_m1    = nr - RLW'(1);
	assign nc_m1    = nc - CLW'(1);
	assign rr_ext   = {{RW{1'b0}}, read_row};
	assign rc_ext   = {{CW{1'b0}}, read_col};

	assign row_end    = (c_q == col_last_q);
	assign scan_last  = row_end && (r_q == row_last_q);
	assign sweep_last = (sweep_q == {AW{1'b1}});

	assign mul_a = (state_q == flt_pkg::ST_SETUP_A) ? dc_q : dr_q;
	assign mul_b = (state_q == flt_pkg::ST_SETUP_A) ? $signed({1'b0, ar_q})
	                                                 : $signed({1'b0, ac_q});
	assign prod  = mul_a * mul_b;

	assign add_a  = row_end ? s_row_q : s_cur_q;
	assign add_b  = row_end ? -SW'(dc_q) : SW'(dr_q);
	assign s_next = add_a + add_b;

	always_comb begin
		state_d = state_q;
		case (state_q)
			flt_pkg::ST_IDLE: begin
				if (accept) begin
					case (op_in)
						flt_pkg::OP_FAULT:
							state_d = (rows_in_use == '0 || cols_in_use == '0)
							          ? flt_pkg::ST_FINISH : flt_pkg::ST_SETUP_A;
						flt_pkg::OP_READ:  state_d = flt_pkg::ST_READ;
						flt_pkg::OP_CLEAR: state_d = flt_pkg::ST_SWEEP;
						default:           state_d = flt_pkg::ST_FINISH;
					endcase
				end
			end
			flt_pkg::ST_SWEEP: begin
				if (sweep_last)
					state_d = reply_q ? flt_pkg::ST_FINISH : flt_pkg::ST_IDLE;
			end
			flt_pkg::ST_SETUP_A: state_d = flt_pkg::ST_SETUP_B;
			flt_pkg::ST_SETUP_B: state_d = flt_pkg::ST_SCAN;
			flt_pkg::ST_SCAN: begin
				if (scan_last)
					state_d = flt_pkg::ST_DRAIN_A;
			end
			flt_pkg::ST_DRAIN_A: state_d = flt_pkg::ST_DRAIN_B;
			flt_pkg::ST_DRAIN_B: state_d = flt_pkg::ST_FINISH;
			flt_pkg::ST_READ:    state_d = flt_pkg::ST_FINISH;
			flt_pkg::ST_FINISH:  state_d = flt_pkg::ST_IDLE;
			default:             state_d = flt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		addr = rd_addr_q;
		case (state_q)
			flt_pkg::ST_SWEEP: begin
				cmd.clear_wr = 1'b1;
				cmd.load_max = sweep_last && reply_q;
				addr         = sweep_q;
			end
			flt_pkg::ST_SCAN: begin
				cmd.visit = 1'b1;
				cmd.rise  = !s_cur_q[SW-1] && (s_cur_q != '0);
				addr      = {r_q, c_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flt_pkg::ST_SWEEP;
			reply_q <= 1'b0;
			sweep_q <= '0;
			r_q     <= '0;
			c_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == flt_pkg::ST_FINISH);
			if (accept) begin
				reply_q <= 1'b1;
				sweep_q <= '0;
				r_q     <= '0;
				c_q     <= '0;
			end else if (state_q == flt_pkg::ST_SWEEP) begin
				sweep_q <= sweep_q + AW'(1);
			end else if (state_q == flt_pkg::ST_SCAN) begin
				if (row_end) begin
					c_q <= '0;
					r_q <= r_q + RW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_in;
			dr_q       <= $signed({1'b0, line_b_row}) - $signed({1'b0, line_a_row});
			dc_q       <= $signed({1'b0, line_b_col}) - $signed({1'b0, line_a_col});
			ar_q       <= line_a_row;
			ac_q       <= line_a_col;
			disp_q     <= displacement;
			row_last_q <= nr_m1[RW-1:0];
			col_last_q <= nc_m1[CW-1:0];
			empty_q    <= (rows_in_use == '0) || (cols_in_use == '0);
			rd_addr_q  <= {rr_ext[RW-1:0], rc_ext[CW-1:0]};
			rd_ok_q    <= (rr_ext < (RW+CO)'(MAX_ROWS)) && (rc_ext < (CW+CO)'(MAX_COLS));
		end
		case (state_q)
			flt_pkg::ST_SETUP_A: s_row_q <= SW'(prod);
			flt_pkg::ST_SETUP_B: begin
				s_row_q <= s_row_q - SW'(prod);
				s_cur_q <= s_row_q - SW'(prod);
			end
			flt_pkg::ST_SCAN: begin
				s_cur_q <= s_next;
				if (row_end)
					s_row_q <= s_next;
			end
			default: ;
		endcase
		if (state_q == flt_pkg::ST_FINISH) begin
			cell_q <= (op_q == flt_pkg::OP_READ && rd_ok_q) ? rd_data : '0;
			maxo_q <= max_cur;
		end
	end

	assign disp        = empty_q ? '0 : disp_q;
	assign done        = done_q;
	assign cell_height = cell_q;
	assign max_height  = maxo_q;

endmodule

>>> src/fault_line_terrain_update.sv
// Top level of the fault-line terrain update block.
// Depends on flt_pkg, flt_cfg, flt_store and flt_ctrl.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with done high, and the
// receiver cannot stall it. Apply-fault walks the configured rows x columns,
// one cell per cycle through the read-modify-write port of the height memory,
// and holds busy while it runs; with zero rows or columns no cell is visited.
// Clear zeroes the memory one entry a cycle over 2^(clog2(MAX_ROWS)+
// clog2(MAX_COLS)) entries (16384 at the defaults). After reset the same
// clearing pass runs with busy high and no result; configuration writes are
// taken at any time.
module fault_line_terrain_update #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      opcode,
	input  logic [flt_pkg::COORD_W-1:0]     line_a_row,
	input  logic [flt_pkg::COORD_W-1:0]     line_a_col,
	input  logic [flt_pkg::COORD_W-1:0]     line_b_row,
	input  logic [flt_pkg::COORD_W-1:0]     line_b_col,
	input  logic [flt_pkg::DISP_W-1:0]      displacement,
	input  logic [flt_pkg::COORD_W-1:0]     read_row,
	input  logic [flt_pkg::COORD_W-1:0]     read_col,
	output logic                            done,
	output logic [flt_pkg::HEIGHT_W-1:0]    cell_height,
	output logic [flt_pkg::HEIGHT_W-1:0]    max_height,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

	logic [flt_pkg::CNT_W-1:0]    rows_in_use;
	logic [flt_pkg::CNT_W-1:0]    cols_in_use;
	logic [flt_pkg::HEIGHT_W-1:0] max_height_start;
	flt_pkg::cmd_t                cmd;
	logic [AW-1:0]                addr;
	logic [flt_pkg::DISP_W-1:0]   disp;
	logic [flt_pkg::HEIGHT_W-1:0] rd_data;
	logic [flt_pkg::HEIGHT_W-1:0] max_cur;

	flt_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.rows_in_use      (rows_in_use),
		.cols_in_use      (cols_in_use),
		.max_height_start (max_height_start)
	);

	flt_store #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.addr       (addr),
		.disp       (disp),
		.max_start  (max_height_start),
		.rd_data    (rd_data),
		.max_height (max_cur)
	);

	flt_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.line_a_row   (line_a_row),
		.line_a_col   (line_a_col),
		.line_b_row   (line_b_row),
		.line_b_col   (line_b_col),
		.displacement (displacement),
		.read_row     (read_row),
		.read_col     (read_col),
		.rows_in_use  (rows_in_use),
		.cols_in_use  (cols_in_use),
		.cmd          (cmd),
		.addr         (addr),
		.disp         (disp),
		.rd_data      (rd_data),
		.max_cur      (max_cur),
		.done         (done),
		.cell_height  (cell_height),
		.max_height   (max_height)
	);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for fault_line_terrain_update: directed table, short climb, random phases.
// Depends on flt_pkg and the RTL top; keeps its own heightmap predictor and checks every result.
module testbench;

	localparam int GRID_ROWS       = 128;
	localparam int GRID_COLS       = 128;
	localparam int WATCHDOG_LIMIT  = 100000;
	localparam int RANDOM_REQUESTS = 70;
	// full-scale rises on one cell back to back
	localparam int CLIMB_STEPS     = 6;

	typedef struct packed {
		flt_pkg::op_t                 op;
		logic [flt_pkg::COORD_W-1:0]  a_row;
		logic [flt_pkg::COORD_W-1:0]  a_col;
		logic [flt_pkg::COORD_W-1:0]  b_row;
		logic [flt_pkg::COORD_W-1:0]  b_col;
		logic [flt_pkg::DISP_W-1:0]   disp;
		logic [flt_pkg::COORD_W-1:0]  rd_row;
		logic [flt_pkg::COORD_W-1:0]  rd_col;
	} terrain_req_t;

	typedef struct packed {
		logic [flt_pkg::HEIGHT_W-1:0] cell_h;
		logic [flt_pkg::HEIGHT_W-1:0] peak;
	} height_result_t;

	typedef struct packed {
		bit                           is_cfg;
		logic [flt_pkg::CNT_W-1:0]    rows;
		logic [flt_pkg::CNT_W-1:0]    cols;
		logic [flt_pkg::HEIGHT_W-1:0] mstart;
		terrain_req_t                 req;
		bit                           typed;
		height_result_t               want;
	} dir_step_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [1:0]                     opcode;
	logic [flt_pkg::COORD_W-1:0]    line_a_row;
	logic [flt_pkg::COORD_W-1:0]    line_a_col;
	logic [flt_pkg::COORD_W-1:0]    line_b_row;
	logic [flt_pkg::COORD_W-1:0]    line_b_col;
	logic [flt_pkg::DISP_W-1:0]     displacement;
	logic [flt_pkg::COORD_W-1:0]    read_row;
	logic [flt_pkg::COORD_W-1:0]    read_col;
	logic                           done;
	logic [flt_pkg::HEIGHT_W-1:0]   cell_height;
	logic [flt_pkg::HEIGHT_W-1:0]   max_height;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [3:0]                     paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;

	// predictor state
	logic [flt_pkg::HEIGHT_W-1:0]   terrain_height [GRID_ROWS*GRID_COLS];
	logic [flt_pkg::HEIGHT_W-1:0]   terrain_peak;
	logic [flt_pkg::CNT_W-1:0]      cfg_rows;
	logic [flt_pkg::CNT_W-1:0]      cfg_cols;
	logic [flt_pkg::HEIGHT_W-1:0]   cfg_mstart;

	height_result_t        expected_heights [$];
	dir_step_t             directed_steps [$];
	int                    mismatch_count = 0;
	int                    quiet_cycles = 0;

	always #6 clk = ~clk;

	fault_line_terrain_update #(
		.MAX_ROWS(GRID_ROWS),
		.MAX_COLS(GRID_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.line_a_row(line_a_row),
		.line_a_col(line_a_col),
		.line_b_row(line_b_row),
		.line_b_col(line_b_col),
		.displacement(displacement),
		.read_row(read_row),
		.read_col(read_col),
		.done(done),
		.cell_height(cell_height),
		.max_height(max_height),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic void wipe_terrain();
		foreach (terrain_height[i]) terrain_height[i] = '0;
	endfunction

	function automatic height_result_t predict_request(terrain_req_t req);
		height_result_t res;
		int nr, nc, dr, dc, s;
		logic [flt_pkg::HEIGHT_W:0] h;
		res.cell_h = '0;
		case (req.op)
		flt_pkg::OP_FAULT: begin
			nr = (cfg_rows > GRID_ROWS) ? GRID_ROWS : int'(cfg_rows);
			nc = (cfg_cols > GRID_COLS) ? GRID_COLS : int'(cfg_cols);
			dr = int'(req.b_row) - int'(req.a_row);
			dc = int'(req.b_col) - int'(req.a_col);
			for (int r = 0; r < nr; r++) begin
				for (int c = 0; c < nc; c++) begin
					h = {1'b0, terrain_height[r*GRID_COLS + c]};
					s = dr * (c - int'(req.a_col)) - dc * (r - int'(req.a_row));
					// cells on the line fall like the negative side
					if (s > 0) begin
						h = h + req.disp;
						if (h > flt_pkg::HEIGHT_TOP) h = flt_pkg::HEIGHT_TOP;
					end else if (h >= req.disp) begin
						h = h - req.disp;
					end
					terrain_height[r*GRID_COLS + c] = h[flt_pkg::HEIGHT_W-1:0];
					if (h[flt_pkg::HEIGHT_W-1:0] > terrain_peak)
						terrain_peak = h[flt_pkg::HEIGHT_W-1:0];
				end
			end
		end
		flt_pkg::OP_READ: begin
			res.cell_h = terrain_height[int'(req.rd_row)*GRID_COLS + int'(req.rd_col)];
		end
		flt_pkg::OP_CLEAR: begin
			wipe_terrain();
			terrain_peak = cfg_mstart;
		end
		default: ;
		endcase
		res.peak = terrain_peak;
		return res;
	endfunction

	function automatic void dir_cfg(int rows, int cols, int mstart);
		dir_step_t st;
		st = '0;
		st.is_cfg = 1'b1;
		st.rows = flt_pkg::CNT_W'(rows);
		st.cols = flt_pkg::CNT_W'(cols);
		st.mstart = flt_pkg::HEIGHT_W'(mstart);
		directed_steps = {directed_steps, st};
	endfunction

	function automatic void dir_req(flt_pkg::op_t op, int ar, int ac, int br, int bc, int d,
			int rr, int rc, bit typed, int ec, int em);
		dir_step_t st;
		st = '0;
		st.req.op = op;
		st.req.a_row = flt_pkg::COORD_W'(ar);
		st.req.a_col = flt_pkg::COORD_W'(ac);
		st.req.b_row = flt_pkg::COORD_W'(br);
		st.req.b_col = flt_pkg::COORD_W'(bc);
		st.req.disp = flt_pkg::DISP_W'(d);
		st.req.rd_row = flt_pkg::COORD_W'(rr);
		st.req.rd_col = flt_pkg::COORD_W'(rc);
		st.typed = typed;
		st.want.cell_h = flt_pkg::HEIGHT_W'(ec);
		st.want.peak = flt_pkg::HEIGHT_W'(em);
		directed_steps = {directed_steps, st};
	endfunction

	task automatic wait_drained();
		while (expected_heights.size() != 0) @(posedge clk);
	endtask

	task automatic sender_gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// leaves start high so a following request can go back to back
	task automatic issue(input terrain_req_t req, input bit typed, input height_result_t want);
		height_result_t predicted;
		opcode <= req.op;
		line_a_row <= req.a_row;
		line_a_col <= req.a_col;
		line_b_row <= req.b_row;
		line_b_col <= req.b_col;
		displacement <= req.disp;
		read_row <= req.rd_row;
		read_col <= req.rd_col;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = predict_request(req);
		if (typed) predicted = want;
		expected_heights = {expected_heights, predicted};
	endtask

	// one APB transfer; psel stays high so transfers can run back to back
	task automatic apb_beat(input flt_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic write_config(input logic [flt_pkg::CNT_W-1:0] rows,
			input logic [flt_pkg::CNT_W-1:0] cols,
			input logic [flt_pkg::HEIGHT_W-1:0] mstart);
		start <= 1'b0;
		wait_drained();
		apb_beat(flt_pkg::REG_ROWS, 32'(rows));
		apb_beat(flt_pkg::REG_COLS, 32'(cols));
		apb_beat(flt_pkg::REG_MSTART, 32'(mstart));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_rows = rows;
		cfg_cols = cols;
		cfg_mstart = mstart;
	endtask

	function automatic void note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
	endfunction

	function automatic void check_result();
		height_result_t want;
		if (expected_heights.size() == 0) begin
			note_failure($sformatf("unexpected result: cell_height %h max_height %h",
				cell_height, max_height));
			return;
		end
		want = expected_heights.pop_front();
		if (cell_height !== want.cell_h)
			note_failure($sformatf("cell_height expected %h got %h", want.cell_h, cell_height));
		if (max_height !== want.peak)
			note_failure($sformatf("max_height expected %h got %h", want.peak, max_height));
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) quiet_cycles = 0;
			else quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else if (done) begin
				check_result();
			end
		end
	end

	initial begin
		terrain_req_t req;
		dir_step_t st;
		height_result_t no_want;
		int kind, pick, n_items, big_phases, sent, r_lim, c_lim;
		int rows_v, cols_v;
		logic [flt_pkg::HEIGHT_W-1:0] mstart_v;
		bit steady, big, near;

		arst_n = 1'b0;
		start = 1'b0;
		opcode = flt_pkg::OP_NOP;
		line_a_row = '0;
		line_a_col = '0;
		line_b_row = '0;
		line_b_col = '0;
		displacement = '0;
		read_row = '0;
		read_col = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_want = '0;

		wipe_terrain();
		terrain_peak = '0;
		cfg_rows = 8'd128;
		cfg_cols = 8'd128;
		cfg_mstart = '0;

		// empty map, extremes of the read coordinates, unused opcode
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,   0,   0, 1, 0, 0);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0, 127, 127, 1, 0, 0);
		dir_req(flt_pkg::OP_NOP,   127, 127, 127, 127, 1023, 127, 127, 1, 0, 0);
		// clear loads the start value into the running max
		dir_cfg(128, 128, 24'hFFFFFF);
		dir_req(flt_pkg::OP_CLEAR,   0,   0,   0,   0,    0,   0,   0, 1, 0, 24'hFFFFFF);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,  64,  64, 1, 0, 24'hFFFFFF);
		dir_cfg(128, 128, 0);
		dir_req(flt_pkg::OP_CLEAR,   0,   0,   0,   0,    0,   0,   0, 1, 0, 0);
		// zero rows or zero columns: nothing visited
		dir_cfg(0, 128, 0);
		dir_req(flt_pkg::OP_FAULT,   0,   0, 127, 127, 1023,   0,   0, 1, 0, 0);
		dir_cfg(4, 0, 0);
		dir_req(flt_pkg::OP_FAULT,   0,   0, 127, 127, 1023,   0,   0, 1, 0, 0);
		dir_cfg(4, 6, 0);
		// degenerate line on an empty map: every fall would go negative
		dir_req(flt_pkg::OP_FAULT,   2,   3,   2,   3, 1023,   0,   0, 1, 0, 0);
		// vertical line at column 0: columns 1.. rise, column 0 is on the line
		dir_req(flt_pkg::OP_FAULT,   0,   0,   3,   0, 1023,   0,   0, 1, 0, 24'h3FF);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,   2,   5, 1, 24'h3FF, 24'h3FF);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,   1,   0, 1, 0, 24'h3FF);
		// everything falls; second fall would go below zero and is skipped
		dir_req(flt_pkg::OP_FAULT,   0,   0,   0,   1, 1000,   0,   0, 1, 0, 24'h3FF);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,   3,   4, 1, 24'h17, 24'h3FF);
		dir_req(flt_pkg::OP_FAULT,   0,   0,   0,   1, 1000,   0,   0, 1, 0, 24'h3FF);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,   3,   4, 1, 24'h17, 24'h3FF);
		dir_req(flt_pkg::OP_FAULT, 127, 127,   0,   0,  512,   0,   0, 0, 0, 0);
		dir_req(flt_pkg::OP_FAULT,   0, 127, 127,   0,    0,   0,   0, 0, 0, 0);
		// counts above the grid size saturate
		dir_cfg(255, 255, 0);
		dir_req(flt_pkg::OP_FAULT,   5,   0,   5, 127,    1,   0,   0, 0, 0, 0);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0, 127,   0, 0, 0, 0);
		dir_req(flt_pkg::OP_READ,    0,   0,   0,   0,    0,   0, 127, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed_steps.size(); i++) begin
			st = directed_steps[i];
			if (st.is_cfg) begin
				write_config(st.rows, st.cols, st.mstart);
			end else begin
				issue(st.req, st.typed, st.want);
				sender_gap($urandom_range(0, 13));
			end
		end

		// cell (0,1) rises by the full step each time, cell (0,0) sits on the line
		write_config(8'd1, 8'd2, 24'd0);
		req = '0;
		req.op = flt_pkg::OP_FAULT;
		req.b_row = 7'd1;
		req.disp = '1;
		for (int i = 0; i < CLIMB_STEPS; i++) issue(req, 1'b0, no_want);
		req = '0;
		req.op = flt_pkg::OP_READ;
		req.rd_col = 7'd1;
		issue(req, 1'b0, no_want);
		req = '0;
		req.op = flt_pkg::OP_FAULT;
		req.b_col = 7'd1;
		req.disp = flt_pkg::DISP_W'($urandom_range(0, 1023));
		issue(req, 1'b0, no_want);

		big_phases = 0;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			kind = $urandom_range(0, 9);
			big = 1'b0;
			rows_v = $urandom_range(1, 12);
			cols_v = $urandom_range(1, 12);
			case (kind)
			0: begin
				if ($urandom_range(0, 1)) rows_v = 0;
				else cols_v = 0;
			end
			1: begin
				if (big_phases < 2) begin
					rows_v = $urandom_range(128, 255);
					cols_v = $urandom_range(128, 255);
					big = 1'b1;
					big_phases++;
				end
			end
			2: begin
				rows_v = $urandom_range(1, 2);
				cols_v = $urandom_range(100, 255);
			end
			3: begin
				rows_v = $urandom_range(100, 255);
				cols_v = $urandom_range(1, 2);
			end
			default: ;
			endcase
			case ($urandom_range(0, 3))
			0: mstart_v = flt_pkg::HEIGHT_W'($urandom_range(0, 24'hFFFFFF));
			1: mstart_v = flt_pkg::HEIGHT_W'($urandom_range(0, 4095));
			default: mstart_v = '0;
			endcase
			write_config(flt_pkg::CNT_W'(rows_v), flt_pkg::CNT_W'(cols_v), mstart_v);

			r_lim = (rows_v == 0) ? 0 : ((rows_v > GRID_ROWS) ? GRID_ROWS : rows_v) - 1;
			c_lim = (cols_v == 0) ? 0 : ((cols_v > GRID_COLS) ? GRID_COLS : cols_v) - 1;
			n_items = big ? 2 : $urandom_range(6, 16);
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n_items && sent < RANDOM_REQUESTS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) req.op = flt_pkg::OP_CLEAR;
				else if (pick < 8) req.op = flt_pkg::OP_NOP;
				else if (pick < 55) req.op = flt_pkg::OP_FAULT;
				else req.op = flt_pkg::OP_READ;
				// lines through or near the used corner cut the grid more often
				near = ($urandom_range(0, 1) == 1);
				req.a_row = flt_pkg::COORD_W'(near ? $urandom_range(0, 15)
				                                   : $urandom_range(0, 127));
				req.a_col = flt_pkg::COORD_W'(near ? $urandom_range(0, 15)
				                                   : $urandom_range(0, 127));
				req.b_row = flt_pkg::COORD_W'(near ? $urandom_range(0, 15)
				                                   : $urandom_range(0, 127));
				req.b_col = flt_pkg::COORD_W'(near ? $urandom_range(0, 15)
				                                   : $urandom_range(0, 127));
				case ($urandom_range(0, 7))
				0: req.disp = '0;
				1: req.disp = '1;
				default: req.disp = flt_pkg::DISP_W'($urandom_range(0, 1023));
				endcase
				if ($urandom_range(0, 3) != 0) begin
					req.rd_row = flt_pkg::COORD_W'($urandom_range(0, r_lim));
					req.rd_col = flt_pkg::COORD_W'($urandom_range(0, c_lim));
				end else begin
					req.rd_row = flt_pkg::COORD_W'($urandom_range(0, 127));
					req.rd_col = flt_pkg::COORD_W'($urandom_range(0, 127));
				end
				issue(req, 1'b0, no_want);
				if (req.op != flt_pkg::OP_NOP) sent++;
				if ($urandom_range(0, 9) == 0) begin
					start <= 1'b0;
					wait_drained();
				end else if (!steady) begin
					sender_gap($urandom_range(0, 13));
				end
			end
		end

		start <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
